FILE: src/assert_macros.svh
// assert_macros.svh: assertion macros for the load monitor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: src/clm_pkg.sv
// clm_pkg: widths, constants, state and handshake types of the load monitor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package clm_pkg;

   localparam int TICK_WIDTH  = 32;
   localparam int PERIOD_LOG2 = 10;
   localparam int LOAD_W      = 10;
   localparam int LOAD_IDX_W  = $clog2(LOAD_W);
   localparam int SER_CNT_W   = $clog2(TICK_WIDTH);

   typedef logic [TICK_WIDTH-1:0] tick_type;
   typedef logic [LOAD_W-1:0]     load_type;

   localparam load_type LOAD_MAX = load_type'(1000);
   localparam logic [LOAD_IDX_W-1:0] LOAD_IDX_TOP = LOAD_IDX_W'(LOAD_W - 1);
   localparam logic [SER_CNT_W-1:0]  SER_LAST     = SER_CNT_W'(TICK_WIDTH - 1);
   localparam tick_type PERIOD_MASK = tick_type'((65'd1 << PERIOD_LOG2) - 65'd1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SERIAL,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic start;
      logic change;
   } ser_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage
`default_nettype wire

FILE: src/clm_serial_acc.sv
// clm_serial_acc: bit-serial tick distance, running sum and denominator.
// Depends on clm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clm_serial_acc (
   input  logic                     clock,
   input  logic                     reset,
   input  clm_pkg::ser_ctrl_type    ctrl,
   input  clm_pkg::tick_type        tick,
   input  clm_pkg::tick_type        since,
   input  clm_pkg::tick_type        acc,
   input  clm_pkg::tick_type        other,
   output clm_pkg::unit_status_type status,
   output clm_pkg::tick_type        new_acc,
   output clm_pkg::tick_type        den
);

   logic                           active_ff, active_in;
   logic                           done_ff, done_in;
   logic [clm_pkg::SER_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           change_ff, change_in;
   clm_pkg::tick_type              tick_sr_ff, tick_sr_in;
   clm_pkg::tick_type              since_sr_ff, since_sr_in;
   clm_pkg::tick_type              acc_sr_ff, acc_sr_in;
   clm_pkg::tick_type              oth_sr_ff, oth_sr_in;
   clm_pkg::tick_type              fwd_sum_ff, fwd_sum_in;
   clm_pkg::tick_type              rev_sum_ff, rev_sum_in;
   clm_pkg::tick_type              fwd_den_ff, fwd_den_in;
   clm_pkg::tick_type              rev_den_ff, rev_den_in;
   logic                           fwd_br_ff, fwd_br_in;
   logic                           rev_br_ff, rev_br_in;
   logic                           fwd_cs_ff, fwd_cs_in;
   logic                           rev_cs_ff, rev_cs_in;
   logic                           fwd_cd_ff, fwd_cd_in;
   logic                           rev_cd_ff, rev_cd_in;

   logic t_bit, s_bit, a_bit, o_bit;
   logic fwd_diff, rev_diff, fwd_add, rev_add;
   logic fwd_sum_bit, rev_sum_bit, fwd_den_bit, rev_den_bit;

   // One bit of every operand per cycle, LSB first. The forward chain takes
   // tick - since, the reverse chain since - tick; the final forward borrow
   // picks the chain that holds the absolute distance.
   always_comb begin
      t_bit = tick_sr_ff[0];
      s_bit = since_sr_ff[0];
      a_bit = acc_sr_ff[0];
      o_bit = oth_sr_ff[0];

      fwd_diff  = t_bit ^ s_bit ^ fwd_br_ff;
      fwd_br_in = (~t_bit & s_bit) | (~(t_bit ^ s_bit) & fwd_br_ff);
      rev_diff  = s_bit ^ t_bit ^ rev_br_ff;
      rev_br_in = (~s_bit & t_bit) | (~(s_bit ^ t_bit) & rev_br_ff);

      fwd_add = change_ff & fwd_diff;
      rev_add = change_ff & rev_diff;

      fwd_sum_bit = a_bit ^ fwd_add ^ fwd_cs_ff;
      fwd_cs_in   = (a_bit & fwd_add) | (fwd_cs_ff & (a_bit ^ fwd_add));
      rev_sum_bit = a_bit ^ rev_add ^ rev_cs_ff;
      rev_cs_in   = (a_bit & rev_add) | (rev_cs_ff & (a_bit ^ rev_add));

      fwd_den_bit = fwd_sum_bit ^ o_bit ^ fwd_cd_ff;
      fwd_cd_in   = (fwd_sum_bit & o_bit) | (fwd_cd_ff & (fwd_sum_bit ^ o_bit));
      rev_den_bit = rev_sum_bit ^ o_bit ^ rev_cd_ff;
      rev_cd_in   = (rev_sum_bit & o_bit) | (rev_cd_ff & (rev_sum_bit ^ o_bit));

      tick_sr_in  = tick_sr_ff >> 1;
      since_sr_in = since_sr_ff >> 1;
      acc_sr_in   = acc_sr_ff >> 1;
      oth_sr_in   = oth_sr_ff >> 1;
      fwd_sum_in  = {fwd_sum_bit, fwd_sum_ff[clm_pkg::TICK_WIDTH-1:1]};
      rev_sum_in  = {rev_sum_bit, rev_sum_ff[clm_pkg::TICK_WIDTH-1:1]};
      fwd_den_in  = {fwd_den_bit, fwd_den_ff[clm_pkg::TICK_WIDTH-1:1]};
      rev_den_in  = {rev_den_bit, rev_den_ff[clm_pkg::TICK_WIDTH-1:1]};
      change_in   = change_ff;
      cnt_in      = cnt_ff + 1'b1;
      active_in   = active_ff;
      done_in     = 1'b0;

      if (ctrl.start) begin
         tick_sr_in  = tick;
         since_sr_in = since;
         acc_sr_in   = acc;
         oth_sr_in   = other;
         fwd_sum_in  = fwd_sum_ff;
         rev_sum_in  = rev_sum_ff;
         fwd_den_in  = fwd_den_ff;
         rev_den_in  = rev_den_ff;
         fwd_br_in   = 1'b0;
         rev_br_in   = 1'b0;
         fwd_cs_in   = 1'b0;
         rev_cs_in   = 1'b0;
         fwd_cd_in   = 1'b0;
         rev_cd_in   = 1'b0;
         change_in   = ctrl.change;
         cnt_in      = '0;
         active_in   = 1'b1;
      end else if (active_ff) begin
         if (cnt_ff == clm_pkg::SER_LAST) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end else begin
         // hold everything once the pass is over
         tick_sr_in  = tick_sr_ff;
         since_sr_in = since_sr_ff;
         acc_sr_in   = acc_sr_ff;
         oth_sr_in   = oth_sr_ff;
         fwd_sum_in  = fwd_sum_ff;
         rev_sum_in  = rev_sum_ff;
         fwd_den_in  = fwd_den_ff;
         rev_den_in  = rev_den_ff;
         fwd_br_in   = fwd_br_ff;
         rev_br_in   = rev_br_ff;
         fwd_cs_in   = fwd_cs_ff;
         rev_cs_in   = rev_cs_ff;
         fwd_cd_in   = fwd_cd_ff;
         rev_cd_in   = rev_cd_ff;
         cnt_in      = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      change_ff   <= change_in;
      tick_sr_ff  <= tick_sr_in;
      since_sr_ff <= since_sr_in;
      acc_sr_ff   <= acc_sr_in;
      oth_sr_ff   <= oth_sr_in;
      fwd_sum_ff  <= fwd_sum_in;
      rev_sum_ff  <= rev_sum_in;
      fwd_den_ff  <= fwd_den_in;
      rev_den_ff  <= rev_den_in;
      fwd_br_ff   <= fwd_br_in;
      rev_br_ff   <= rev_br_in;
      fwd_cs_ff   <= fwd_cs_in;
      rev_cs_ff   <= rev_cs_in;
      fwd_cd_ff   <= fwd_cd_in;
      rev_cd_ff   <= rev_cd_in;
   end

   // forward borrow out means tick < since: take the reverse chain
   assign new_acc     = fwd_br_ff ? rev_sum_ff : fwd_sum_ff;
   assign den         = fwd_br_ff ? rev_den_ff : fwd_den_ff;
   assign status.busy = active_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

FILE: src/clm_share_div.sv
// clm_share_div: iterative floor(LOAD_MAX * b / d), saturating at LOAD_MAX, one step per cycle.
// Depends on clm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clm_share_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  clm_pkg::tick_type        busy_val,
   input  clm_pkg::tick_type        den_val,
   output clm_pkg::unit_status_type status,
   output clm_pkg::load_type        quot
);

   logic                            active_ff, active_in;
   logic                            done_ff, done_in;
   logic                            add_ff, add_in;
   logic [clm_pkg::LOAD_IDX_W-1:0]  idx_ff, idx_in;
   clm_pkg::tick_type               r_ff, r_in;
   clm_pkg::tick_type               b_ff, b_in;
   clm_pkg::tick_type               d_ff, d_in;
   clm_pkg::load_type               q_ff, q_in;

   clm_pkg::tick_type sub_val, diff, r_step;
   logic              ge;

   // Doubling step uses r as addend, constant-bit step uses b. Remainder
   // stays below d, so r + sub never wraps when the compare fails.
   always_comb begin
      sub_val = add_ff ? b_ff : r_ff;
      diff    = d_ff - sub_val;
      ge      = (r_ff >= diff);
      r_step  = ge ? (r_ff - diff) : (r_ff + sub_val);

      active_in = active_ff;
      done_in   = 1'b0;
      add_in    = add_ff;
      idx_in    = idx_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      d_in      = d_ff;
      q_in      = q_ff;

      if (start) begin
         b_in   = busy_val;
         d_in   = den_val;
         r_in   = '0;
         add_in = 1'b0;
         idx_in = clm_pkg::LOAD_IDX_TOP;
         if (busy_val >= den_val) begin
            // share of one or more: saturate
            q_in    = clm_pkg::LOAD_MAX;
            done_in = 1'b1;
         end else begin
            q_in      = '0;
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         r_in = r_step;
         if (add_ff) begin
            q_in   = q_ff + clm_pkg::load_type'(ge);
            add_in = 1'b0;
         end else begin
            q_in   = {q_ff[clm_pkg::LOAD_W-2:0], ge};
            add_in = clm_pkg::LOAD_MAX[idx_ff];
         end
         if (add_ff || !clm_pkg::LOAD_MAX[idx_ff]) begin
            if (idx_ff == '0) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         add_ff    <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         add_ff    <= add_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      b_ff <= b_in;
      d_ff <= d_in;
      q_ff <= q_in;
   end

   assign status.busy = active_ff;
   assign status.done = done_ff;
   assign quot        = q_ff;

endmodule
`default_nettype wire

FILE: src/cpu_load_monitor.sv
// cpu_load_monitor: CPU load estimate from scheduler switch events.
// Depends on clm_pkg, clm_serial_acc, clm_share_div and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_timestamp, req_idle_now
//   rsp     | out       | rsp_valid / rsp_stall | rsp_cpu_load, rsp_load_updated
//
// One request at a time. A request runs through the bit-serial
// accumulator (one tick bit per cycle, TICK_WIDTH bits) before the next
// accept. A period end with a nonzero sum adds a pass through the share
// divider (one step per cycle).
// Reset (synchronous) clears the sums, start times, idle flag and load.
// A stalled response holds in the output register; a new request is taken
// meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpu_load_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_timestamp,
   input  logic        req_idle_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_cpu_load,
   output logic        rsp_load_updated
);

   clm_pkg::state_type state_ff, state_in;

   // scheduler bookkeeping
   clm_pkg::tick_type busy_start_ff, busy_start_in;
   clm_pkg::tick_type idle_start_ff, idle_start_in;
   clm_pkg::tick_type busy_sum_ff, busy_sum_in;
   clm_pkg::tick_type idle_sum_ff, idle_sum_in;
   logic              was_idle_ff, was_idle_in;
   clm_pkg::load_type load_value_ff, load_value_in;

   // request held while it is worked on
   clm_pkg::tick_type tick_ff, tick_in;
   logic              idle_now_ff, idle_now_in;
   logic              change_ff, change_in;
   logic              boundary_ff, boundary_in;
   logic              updated_ff, updated_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   clm_pkg::load_type rsp_load_ff, rsp_load_in;
   logic              rsp_upd_ff, rsp_upd_in;

   clm_pkg::tick_type        tick;
   logic                     accept;
   logic                     change;
   logic                     ser_done;
   logic                     den_zero;
   logic                     div_start;
   logic                     out_load;
   clm_pkg::ser_ctrl_type    ser_ctrl;
   clm_pkg::unit_status_type ser_status;
   clm_pkg::unit_status_type div_status;
   clm_pkg::tick_type        ser_since, ser_acc, ser_other;
   clm_pkg::tick_type        new_acc, den;
   clm_pkg::tick_type        div_busy;
   clm_pkg::load_type        quot;

   // truncate or zero-extend the timestamp to the tick width
   assign tick   = clm_pkg::tick_type'(req_timestamp);
   assign accept = req_valid && !req_stall;
   assign change = (was_idle_ff != req_idle_now);

   // Entering idle grows the busy sum from busy_start; leaving idle grows
   // the idle sum from idle_start. An unchanged flag adds zero.
   assign ser_since = req_idle_now ? busy_start_ff : idle_start_ff;
   assign ser_acc   = req_idle_now ? busy_sum_ff   : idle_sum_ff;
   assign ser_other = req_idle_now ? idle_sum_ff   : busy_sum_ff;

   assign ser_ctrl.start  = accept;
   assign ser_ctrl.change = change;

   clm_serial_acc u_serial (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ser_ctrl),
      .tick    (tick),
      .since   (ser_since),
      .acc     (ser_acc),
      .other   (ser_other),
      .status  (ser_status),
      .new_acc (new_acc),
      .den     (den)
   );

   // busy sum after this event, before the period clear
   assign div_busy = idle_now_ff ? new_acc : busy_sum_ff;
   assign ser_done = (state_ff == clm_pkg::ST_SERIAL) && ser_status.done;
   assign den_zero = (den == '0);

   clm_share_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .busy_val (div_busy),
      .den_val  (den),
      .status   (div_status),
      .quot     (quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clm_pkg::ST_IDLE: begin
            if (req_valid) state_in = clm_pkg::ST_SERIAL;
         end
         clm_pkg::ST_SERIAL: begin
            if (ser_status.done) begin
               if (boundary_ff && !den_zero) state_in = clm_pkg::ST_DIVIDE;
               else                          state_in = clm_pkg::ST_WRITE;
            end
         end
         clm_pkg::ST_DIVIDE: begin
            if (div_status.done) state_in = clm_pkg::ST_WRITE;
         end
         clm_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = clm_pkg::ST_IDLE;
         end
         default: state_in = clm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         clm_pkg::ST_IDLE:   req_stall = 1'b0;
         clm_pkg::ST_SERIAL: div_start = ser_status.done && boundary_ff && !den_zero;
         clm_pkg::ST_DIVIDE: div_start = 1'b0;
         clm_pkg::ST_WRITE:  out_load  = !rsp_valid_ff || !rsp_stall;
         default:            req_stall = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      busy_start_in = busy_start_ff;
      idle_start_in = idle_start_ff;
      busy_sum_in   = busy_sum_ff;
      idle_sum_in   = idle_sum_ff;
      was_idle_in   = was_idle_ff;
      load_value_in = load_value_ff;
      tick_in       = tick_ff;
      idle_now_in   = idle_now_ff;
      change_in     = change_ff;
      boundary_in   = boundary_ff;
      updated_in    = updated_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      // capture the request and advance the idle flag
      if (accept) begin
         tick_in     = tick;
         idle_now_in = req_idle_now;
         change_in   = change;
         boundary_in = ((tick & clm_pkg::PERIOD_MASK) == '0);
         was_idle_in = req_idle_now;
      end

      // commit sums and start times once the serial pass ends
      if (ser_done) begin
         updated_in = 1'b0;
         if (change_ff) begin
            if (idle_now_ff) idle_start_in = tick_ff;
            else             busy_start_in = tick_ff;
         end
         if (idle_now_ff) busy_sum_in = new_acc;
         else             idle_sum_in = new_acc;
         // period end: drop both sums, the divider already holds its operands
         if (boundary_ff) begin
            busy_sum_in = '0;
            idle_sum_in = '0;
         end
      end

      if ((state_ff == clm_pkg::ST_DIVIDE) && div_status.done) begin
         load_value_in = quot;
         updated_in    = 1'b1;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_load_in  = load_value_ff;
         rsp_upd_in   = updated_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clm_pkg::ST_IDLE;
         busy_start_ff <= '0;
         idle_start_ff <= '0;
         busy_sum_ff   <= '0;
         idle_sum_ff   <= '0;
         was_idle_ff   <= 1'b0;
         load_value_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_start_ff <= busy_start_in;
         idle_start_ff <= idle_start_in;
         busy_sum_ff   <= busy_sum_in;
         idle_sum_ff   <= idle_sum_in;
         was_idle_ff   <= was_idle_in;
         load_value_ff <= load_value_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff     <= tick_in;
      idle_now_ff <= idle_now_in;
      change_ff   <= change_in;
      boundary_ff <= boundary_in;
      updated_ff  <= updated_in;
      rsp_load_ff <= rsp_load_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cpu_load     = rsp_load_ff;
   assign rsp_load_updated = rsp_upd_ff;

   `CLM_ASSERT_NEXT(a_accept_starts_serial, clock, reset, accept, state_ff == clm_pkg::ST_SERIAL && ser_status.busy)
   `CLM_ASSERT_SAME(a_div_only_in_divide, clock, reset, div_status.busy, state_ff == clm_pkg::ST_DIVIDE)
   `CLM_ASSERT_SAME(a_serial_only_in_serial, clock, reset, ser_status.busy, state_ff == clm_pkg::ST_SERIAL)
   `CLM_ASSERT_SAME(a_load_in_range, clock, reset, rsp_valid_ff, rsp_load_ff <= clm_pkg::LOAD_MAX)

endmodule
`default_nettype wire

FILE: bench/cpu_load_monitor_tb.sv
// cpu_load_monitor_tb: self-checking bench for the CPU load monitor.
// Depends on clm_pkg and the cpu_load_monitor RTL; needs no other files.
`timescale 1ns / 1ps
module cpu_load_monitor_tb;

   localparam int  LIMIT_CYCLES = 400000;
   localparam int  SETTLE_CYCLES = 80;       // a divide pass plus slack
   localparam int  RANDOM_EVENTS = 530;
   localparam clm_pkg::tick_type PERIOD_TICKS =
      clm_pkg::tick_type'(1) << clm_pkg::PERIOD_LOG2;

   // One scheduler event waiting to go out; drain asks the driver to hold
   // it back until every outstanding load report has come home.
   typedef struct packed {
      clm_pkg::tick_type stamp;
      logic              idle;
      logic              drain;
   } sched_event_type;

   typedef struct packed {
      clm_pkg::load_type load;
      logic              updated;
   } load_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   clm_pkg::tick_type req_timestamp = '0;
   logic              req_idle_now = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   clm_pkg::load_type rsp_cpu_load;
   logic              rsp_load_updated;

   sched_event_type event_q[$];
   load_report_type load_expect_q[$];
   int              total_events = 0;
   int              accepted_count = 0;
   int              returned_count = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   // Shadow of the block's accumulator state.
   clm_pkg::tick_type run_start;      // last switch away from idle
   clm_pkg::tick_type rest_start;     // last switch into idle
   clm_pkg::tick_type busy_ticks;
   clm_pkg::tick_type idle_ticks;
   logic              prev_idle;
   clm_pkg::load_type cur_load;

   cpu_load_monitor u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_timestamp    (req_timestamp),
      .req_idle_now     (req_idle_now),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cpu_load     (rsp_cpu_load),
      .rsp_load_updated (rsp_load_updated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string what);
      error_count++;
      $display("[%0t] load monitor error: %s", $time, what);
   endtask

   task automatic add_event(input clm_pkg::tick_type stamp, input logic idle,
                            input logic drain);
      sched_event_type ev;
      ev.stamp = stamp;
      ev.idle  = idle;
      ev.drain = drain;
      event_q.push_back(ev);
   endtask

   // Advance the shadow state by one event and return the report it yields.
   function automatic load_report_type predict_load(input clm_pkg::tick_type stamp,
                                                    input logic idle);
      load_report_type   rep;
      clm_pkg::tick_type span;
      clm_pkg::tick_type den;
      logic [41:0]       scaled;
      rep.updated = 1'b0;
      if (idle != prev_idle) begin
         if (idle) begin
            span = (stamp > run_start) ? stamp - run_start : run_start - stamp;
            busy_ticks = busy_ticks + span;
            rest_start = stamp;
         end else begin
            span = (stamp > rest_start) ? stamp - rest_start : rest_start - stamp;
            idle_ticks = idle_ticks + span;
            run_start = stamp;
         end
      end
      // Close the period on a boundary tick; the sums clear either way.
      if ((stamp & clm_pkg::PERIOD_MASK) == '0) begin
         den = busy_ticks + idle_ticks;
         if (den != '0) begin
            if (busy_ticks >= den) begin
               cur_load = clm_pkg::LOAD_MAX;   // a share of one or more (or a wrapped denominator) saturates
            end else begin
               scaled   = 42'(busy_ticks) * 42'd1000;
               cur_load = clm_pkg::load_type'(scaled / 42'(den));
            end
            rep.updated = 1'b1;
         end
         busy_ticks = '0;
         idle_ticks = '0;
      end
      prev_idle = idle;
      rep.load  = cur_load;
      return rep;
   endfunction

   // Request driver: present queued events, hold a stalled request, and
   // insert gaps according to the current idling phase.
   always @(posedge clock) begin : drive_events
      logic taken;
      logic present;
      int   gap_pct;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         run_start  = '0;
         rest_start = '0;
         busy_ticks = '0;
         idle_ticks = '0;
         prev_idle  = 1'b0;
         cur_load   = '0;
      end else begin
         if (taken) begin
            load_expect_q.push_back(predict_load(req_timestamp, req_idle_now));
            accepted_count++;
         end
         if (accepted_count < total_events / 3) begin
            gap_pct = 10;
         end else if (accepted_count < (2 * total_events) / 3) begin
            gap_pct = 62;
         end else begin
            gap_pct = 0;
         end
         // Hold the payload while the block stalls; load the next one only
         // once the current request is gone.
         present = req_valid && !taken;
         if (!present && event_q.size() != 0 && $urandom_range(99) >= gap_pct &&
             !(event_q[0].drain && load_expect_q.size() != 0)) begin
            req_timestamp <= event_q[0].stamp;
            req_idle_now  <= event_q[0].idle;
            void'(event_q.pop_front());
            present = 1'b1;
         end
         req_valid <= present;
      end
   end

   // Response monitor: compare each accepted report with the oldest
   // prediction, and draw the next stall from the current idling phase.
   always @(posedge clock) begin : check_loads
      load_report_type want;
      int              stall_pct;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            returned_count++;
            if (load_expect_q.size() == 0) begin
               report_error($sformatf("unexpected report load=%0d updated=%0b",
                                      rsp_cpu_load, rsp_load_updated));
            end else begin
               want = load_expect_q.pop_front();
               if (rsp_cpu_load !== want.load)
                  report_error($sformatf("report %0d: cpu_load %0d, want %0d",
                                         returned_count, rsp_cpu_load, want.load));
               if (rsp_load_updated !== want.updated)
                  report_error($sformatf("report %0d: load_updated %0b, want %0b",
                                         returned_count, rsp_load_updated, want.updated));
            end
         end
         if (returned_count < total_events / 3) begin
            stall_pct = 62;
         end else if (returned_count < (2 * total_events) / 3) begin
            stall_pct = 10;
         end else begin
            stall_pct = 0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      clm_pkg::tick_type now_ts;
      logic              flag;
      int                pick;
      int                i;

      // Directed part, starting from the reset state.
      add_event(32'h0000_0000, 1'b0, 1'b0);   // boundary with nothing summed
      add_event(32'h0000_0123, 1'b0, 1'b0);   // flag unchanged, off boundary
      add_event(32'hF000_0000, 1'b1, 1'b0);   // enter idle after a huge busy span
      add_event(32'h0000_0400, 1'b0, 1'b0);   // step back in time, distance taken as absolute
      add_event(32'hFFFF_FFFF, 1'b1, 1'b0);   // all-ones tick
      add_event(32'h0000_0000, 1'b0, 1'b0);   // wrapped denominator
      add_event(32'h0000_1000, 1'b1, 1'b1);   // busy only: full load
      add_event(32'h0000_1000, 1'b0, 1'b0);   // zero-length idle, zero sum
      add_event(32'h0000_1000, 1'b1, 1'b0);   // zero-length busy, zero sum
      add_event(32'h0000_1C00, 1'b0, 1'b0);   // idle only: zero load
      add_event(32'h0000_1D2C, 1'b1, 1'b0);
      add_event(32'h0000_1E00, 1'b1, 1'b0);   // flag unchanged, off boundary
      add_event(32'h0000_1F5B, 1'b0, 1'b0);
      add_event(32'h0000_2000, 1'b1, 1'b0);   // mixed period closes
      add_event(32'h0000_2001, 1'b1, 1'b0);
      add_event(32'h0000_2400, 1'b1, 1'b0);   // unchanged flag on boundary
      add_event(32'h0000_2401, 1'b0, 1'b0);
      add_event(32'h0000_2402, 1'b1, 1'b0);
      add_event(32'h0000_2800, 1'b0, 1'b0);   // tiny busy share
      add_event(32'h7FFF_FC00, 1'b1, 1'b0);   // long busy stretch
      add_event(32'h8000_0000, 1'b0, 1'b0);   // idle-only period closes: zero load, top bit set

      // Random part: mostly ordered schedules that toggle the flag and
      // regularly land on period boundaries; the rest is pure noise.
      now_ts = $urandom;
      flag   = 1'b0;
      for (i = 0; i < RANDOM_EVENTS; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            add_event($urandom, 1'($urandom_range(1)), 1'b0);
         end else begin
            if (pick < 38) begin
               now_ts = (now_ts | (PERIOD_TICKS - 1)) + 1;
            end else if (pick < 48) begin
               now_ts = now_ts + clm_pkg::tick_type'($urandom_range(1, 1 << 20));
            end else begin
               now_ts = now_ts + clm_pkg::tick_type'($urandom_range(0, 400));
            end
            if ($urandom_range(99) < 75)
               flag = ~flag;
            add_event(now_ts, flag, (i == 180) || (i == 360) || ($urandom_range(99) == 0));
         end
      end
      total_events = event_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait for the last request, then for its report, then settle.
      while (event_q.size() != 0 || req_valid)
         @(posedge clock);
      while (load_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (load_expect_q.size() != 0)
         report_error($sformatf("%0d reports never arrived", load_expect_q.size()));
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/clm_pkg.sv
src/clm_serial_acc.sv
src/clm_share_div.sv
src/cpu_load_monitor.sv
bench/cpu_load_monitor_tb.sv
